>>> rtl/first_fit_heap_allocator_defines.svh
// Assertion macros used by the heap allocator controller.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FFHA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ffha_pkg.sv
// Types, constants and command and status structures of the heap allocator.
package ffha_pkg;

  localparam int unsigned HEAP_QUANTA_COUNT = 8192;
  localparam int unsigned QUANTUM_BYTES     = 64;
  localparam int unsigned QSHIFT            = $clog2(QUANTUM_BYTES);
  localparam int unsigned IDX_W             = $clog2(HEAP_QUANTA_COUNT);
  localparam int unsigned ENT_W             = IDX_W + 2;
  localparam int unsigned PTR_W             = IDX_W + 2;
  localparam int unsigned D_W               = ENT_W + 1;
  localparam int unsigned ADDR_W            = 48;
  localparam int unsigned SIZE_W            = 32;
  localparam int unsigned COPY_W            = 14;
  localparam int unsigned Q_W               = SIZE_W + 1 - QSHIFT;
  localparam int unsigned HEAP_SIZE_BYTES   = HEAP_QUANTA_COUNT * QUANTUM_BYTES;

  typedef enum logic [1:0] {
    K_ALLOC   = 2'd0,
    K_FREE    = 2'd1,
    K_REALLOC = 2'd2,
    K_UNKNOWN = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_BAD     = 2'd2,
    ST_CORRUPT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    R_FIND,
    R_I,
    R_J,
    R_NEXT
  } rsel_e;

  typedef enum logic [2:0] {
    W_CLR,
    W_SPLIT,
    W_USE,
    W_FREE,
    W_ZERO,
    W_MHEAD,
    W_KZERO
  } wsel_e;

  typedef enum logic [1:0] {
    RES_NULL,
    RES_ALLOC,
    RES_ADDR
  } ressel_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_A_CHK,
    S_M0,
    S_M1,
    S_A_DEC,
    S_A_W1,
    S_A_W2,
    S_A_W3,
    S_F_D,
    S_F_W,
    S_R_D,
    S_R_CMP,
    S_G_DEC,
    S_FIN
  } state_e;

  typedef struct packed {
    logic    ld_in;
    logic    ld_find;
    logic    ld_q;
    logic    ld_oq;
    logic    ld_out;
    logic    i_zero;
    logic    i_adv;
    logic    i_ridx;
    logic    k_i;
    logic    k_j;
    logic    d_clr;
    logic    d_rd;
    logic    d_acc;
    logic    d_oq;
    logic    d_grow;
    logic    re;
    rsel_e   rsel;
    logic    we;
    wsel_e   wsel;
    logic    clr_step;
    logic    fin;
    status_e st;
    ressel_e res;
    logic    cp;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  too_big;
    logic  addr_null;
    logic  find_bad;
    logic  clr_last;
    logic  rdv_pos;
    logic  rdv_neg;
    logic  d_pos;
    logic  d_neg;
    logic  d_ge_q;
    logic  d_eq_q;
    logic  i_fits;
    logic  oq_eq_q;
    logic  oq_gt_q;
    logic  grow_ok;
    logic  grow_eq;
    logic  dirty;
  } sts_t;

endpackage

>>> rtl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator with free chunk coalescing.
// After reset a clearing pass initialises every entry of the chunk table; no request is taken until it ends.
// A walk visits the chunks in turn and merges each free chunk with the free chunks that follow it.
// A result waits in an output register, so the next request is taken while it is pending.
// Reset is asynchronous and active low; base_address returns to zero.
module first_fit_heap_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ffha_pkg::ADDR_W-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  kind_i,
  input  logic [ffha_pkg::ADDR_W-1:0] address_i,
  input  logic [ffha_pkg::SIZE_W-1:0] size_bytes_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ffha_pkg::ADDR_W-1:0] block_address_o,
  output logic [1:0]                  status_o,
  output logic [ffha_pkg::COPY_W-1:0] copy_quanta_o
);

  ffha_pkg::cmd_t cmd;
  ffha_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  ffha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffha_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .kind_i         (kind_i),
    .address_i      (address_i),
    .size_bytes_i   (size_bytes_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .block_address_o(block_address_o),
    .status_o       (status_o),
    .copy_quanta_o  (copy_quanta_o)
  );

endmodule

>>> rtl/ffha_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ffha_ctrl.sv
// Controller state machine that sequences the chunk table walk and updates.
`include "first_fit_heap_allocator_defines.svh"

module ffha_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  ffha_pkg::sts_t sts_i,
  output ffha_pkg::cmd_t cmd_o
);

  ffha_pkg::state_e state_q, state_d;
  logic             grow_q, grow_d;
  logic             fb_q, fb_d;
  logic             outv_q, outv_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffha_pkg::S_CLEAR;
      grow_q  <= 1'b0;
      fb_q    <= 1'b0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      grow_q  <= grow_d;
      fb_q    <= fb_d;
      outv_q  <= outv_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    grow_d     = grow_q;
    fb_d       = fb_q;
    outv_d     = outv_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    if (outv_q && out_ready_i) begin
      outv_d = 1'b0;
    end
    case (state_q)
      ffha_pkg::S_CLEAR: begin
        cmd_o.we       = 1'b1;
        cmd_o.wsel     = ffha_pkg::W_CLR;
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ffha_pkg::S_IDLE;
        end
      end
      ffha_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          state_d     = ffha_pkg::S_DECODE;
        end
      end
      ffha_pkg::S_DECODE: begin
        fb_d   = 1'b0;
        grow_d = 1'b0;
        case (sts_i.kind)
          ffha_pkg::K_ALLOC, ffha_pkg::K_REALLOC: begin
            if (sts_i.kind == ffha_pkg::K_ALLOC || sts_i.addr_null) begin
              if (sts_i.too_big) begin
                cmd_o.fin = 1'b1;
                cmd_o.st  = ffha_pkg::ST_OOM;
                state_d   = ffha_pkg::S_FIN;
              end else begin
                cmd_o.ld_q   = 1'b1;
                cmd_o.i_zero = 1'b1;
                state_d      = ffha_pkg::S_A_CHK;
              end
            end else if (sts_i.find_bad) begin
              cmd_o.fin = 1'b1;
              cmd_o.st  = ffha_pkg::ST_BAD;
              state_d   = ffha_pkg::S_FIN;
            end else begin
              cmd_o.ld_find = 1'b1;
              cmd_o.re      = 1'b1;
              cmd_o.rsel    = ffha_pkg::R_FIND;
              state_d       = ffha_pkg::S_R_D;
            end
          end
          ffha_pkg::K_FREE: begin
            if (sts_i.addr_null) begin
              cmd_o.fin = 1'b1;
              cmd_o.st  = ffha_pkg::ST_OK;
              state_d   = ffha_pkg::S_FIN;
            end else if (sts_i.find_bad) begin
              cmd_o.fin = 1'b1;
              cmd_o.st  = ffha_pkg::ST_BAD;
              state_d   = ffha_pkg::S_FIN;
            end else begin
              cmd_o.ld_find = 1'b1;
              cmd_o.re      = 1'b1;
              cmd_o.rsel    = ffha_pkg::R_FIND;
              state_d       = ffha_pkg::S_F_D;
            end
          end
          default: begin
            cmd_o.fin = 1'b1;
            cmd_o.st  = ffha_pkg::ST_BAD;
            state_d   = ffha_pkg::S_FIN;
          end
        endcase
      end
      ffha_pkg::S_A_CHK: begin
        grow_d = 1'b0;
        if (!sts_i.i_fits) begin
          cmd_o.fin = 1'b1;
          cmd_o.st  = ffha_pkg::ST_OOM;
          state_d   = ffha_pkg::S_FIN;
        end else begin
          cmd_o.k_i   = 1'b1;
          cmd_o.d_clr = 1'b1;
          cmd_o.re    = 1'b1;
          cmd_o.rsel  = ffha_pkg::R_I;
          state_d     = ffha_pkg::S_M0;
        end
      end
      ffha_pkg::S_M0: begin
        cmd_o.d_rd = 1'b1;
        if (sts_i.rdv_pos) begin
          cmd_o.re   = 1'b1;
          cmd_o.rsel = ffha_pkg::R_NEXT;
          state_d    = ffha_pkg::S_M1;
        end else begin
          state_d = grow_q ? ffha_pkg::S_G_DEC : ffha_pkg::S_A_DEC;
        end
      end
      ffha_pkg::S_M1: begin
        if (sts_i.rdv_pos) begin
          cmd_o.d_acc = 1'b1;
          cmd_o.we    = 1'b1;
          cmd_o.wsel  = ffha_pkg::W_ZERO;
          cmd_o.re    = 1'b1;
          cmd_o.rsel  = ffha_pkg::R_NEXT;
        end else begin
          if (sts_i.dirty) begin
            cmd_o.we   = 1'b1;
            cmd_o.wsel = ffha_pkg::W_MHEAD;
          end
          state_d = grow_q ? ffha_pkg::S_G_DEC : ffha_pkg::S_A_DEC;
        end
      end
      ffha_pkg::S_A_DEC: begin
        if (sts_i.d_ge_q) begin
          state_d = sts_i.d_eq_q ? ffha_pkg::S_A_W2 : ffha_pkg::S_A_W1;
        end else if (sts_i.d_pos || sts_i.d_neg) begin
          cmd_o.i_adv = 1'b1;
          state_d     = ffha_pkg::S_A_CHK;
        end else begin
          cmd_o.fin = 1'b1;
          cmd_o.st  = ffha_pkg::ST_CORRUPT;
          state_d   = ffha_pkg::S_FIN;
        end
      end
      ffha_pkg::S_A_W1: begin
        cmd_o.we   = 1'b1;
        cmd_o.wsel = ffha_pkg::W_SPLIT;
        state_d    = ffha_pkg::S_A_W2;
      end
      ffha_pkg::S_A_W2: begin
        cmd_o.we   = 1'b1;
        cmd_o.wsel = ffha_pkg::W_USE;
        if (fb_q) begin
          state_d = ffha_pkg::S_A_W3;
        end else begin
          cmd_o.fin = 1'b1;
          cmd_o.st  = ffha_pkg::ST_OK;
          cmd_o.res = ffha_pkg::RES_ALLOC;
          state_d   = ffha_pkg::S_FIN;
        end
      end
      ffha_pkg::S_A_W3: begin
        cmd_o.we   = 1'b1;
        cmd_o.wsel = ffha_pkg::W_FREE;
        cmd_o.fin  = 1'b1;
        cmd_o.st   = ffha_pkg::ST_OK;
        cmd_o.res  = ffha_pkg::RES_ALLOC;
        cmd_o.cp   = 1'b1;
        state_d    = ffha_pkg::S_FIN;
      end
      ffha_pkg::S_F_D: begin
        if (!sts_i.rdv_neg) begin
          cmd_o.fin = 1'b1;
          cmd_o.st  = ffha_pkg::ST_BAD;
          state_d   = ffha_pkg::S_FIN;
        end else begin
          cmd_o.ld_oq = 1'b1;
          state_d     = ffha_pkg::S_F_W;
        end
      end
      ffha_pkg::S_F_W: begin
        cmd_o.we   = 1'b1;
        cmd_o.wsel = ffha_pkg::W_FREE;
        cmd_o.fin  = 1'b1;
        cmd_o.st   = ffha_pkg::ST_OK;
        state_d    = ffha_pkg::S_FIN;
      end
      ffha_pkg::S_R_D: begin
        if (!sts_i.rdv_neg) begin
          cmd_o.fin = 1'b1;
          cmd_o.st  = ffha_pkg::ST_BAD;
          state_d   = ffha_pkg::S_FIN;
        end else begin
          cmd_o.ld_oq = 1'b1;
          cmd_o.ld_q  = 1'b1;
          state_d     = ffha_pkg::S_R_CMP;
        end
      end
      ffha_pkg::S_R_CMP: begin
        if (sts_i.oq_eq_q) begin
          cmd_o.fin = 1'b1;
          cmd_o.st  = ffha_pkg::ST_OK;
          cmd_o.res = ffha_pkg::RES_ADDR;
          state_d   = ffha_pkg::S_FIN;
        end else if (sts_i.oq_gt_q) begin
          cmd_o.i_ridx = 1'b1;
          cmd_o.d_oq   = 1'b1;
          state_d      = ffha_pkg::S_A_W1;
        end else begin
          cmd_o.k_j   = 1'b1;
          cmd_o.d_clr = 1'b1;
          cmd_o.re    = 1'b1;
          cmd_o.rsel  = ffha_pkg::R_J;
          grow_d      = 1'b1;
          state_d     = ffha_pkg::S_M0;
        end
      end
      ffha_pkg::S_G_DEC: begin
        grow_d = 1'b0;
        if (sts_i.grow_ok) begin
          cmd_o.we     = 1'b1;
          cmd_o.wsel   = ffha_pkg::W_KZERO;
          cmd_o.i_ridx = 1'b1;
          cmd_o.d_grow = 1'b1;
          state_d      = sts_i.grow_eq ? ffha_pkg::S_A_W2 : ffha_pkg::S_A_W1;
        end else if (sts_i.too_big) begin
          cmd_o.fin = 1'b1;
          cmd_o.st  = ffha_pkg::ST_OOM;
          state_d   = ffha_pkg::S_FIN;
        end else begin
          cmd_o.i_zero = 1'b1;
          fb_d         = 1'b1;
          state_d      = ffha_pkg::S_A_CHK;
        end
      end
      ffha_pkg::S_FIN: begin
        if (!outv_q || out_ready_i) begin
          cmd_o.ld_out = 1'b1;
          outv_d       = 1'b1;
          state_d      = ffha_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ffha_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = outv_q;

  `FFHA_ASSERT_NEXT(a_accept_decodes, in_valid_i && in_ready_o,
    state_q == ffha_pkg::S_DECODE, "accepted request did not reach decode")
  `FFHA_ASSERT_NEXT(a_fin_presents, (state_q == ffha_pkg::S_FIN) && (!outv_q || out_ready_i),
    outv_q, "finished result was not presented")
  `FFHA_ASSERT_NOW(a_no_idle_write, state_q == ffha_pkg::S_IDLE,
    !cmd_o.we, "table written while idle")

endmodule

>>> rtl/ffha_dp.sv
// Datapath: request and result registers, table address arithmetic and the chunk table.
module ffha_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [ffha_pkg::ADDR_W-1:0]   cfg_data_i,
  input  logic [1:0]                    kind_i,
  input  logic [ffha_pkg::ADDR_W-1:0]   address_i,
  input  logic [ffha_pkg::SIZE_W-1:0]   size_bytes_i,
  input  ffha_pkg::cmd_t                cmd_i,
  output ffha_pkg::sts_t                sts_o,
  output logic [ffha_pkg::ADDR_W-1:0]   block_address_o,
  output logic [1:0]                    status_o,
  output logic [ffha_pkg::COPY_W-1:0]   copy_quanta_o
);

  localparam int unsigned N   = ffha_pkg::HEAP_QUANTA_COUNT;
  localparam int unsigned AW  = ffha_pkg::PTR_W + 2;
  localparam int unsigned QXW = ffha_pkg::Q_W + 2;

  logic [ffha_pkg::ADDR_W-1:0]       base_q;
  logic [ffha_pkg::IDX_W-1:0]        cnt_q;
  logic                              oob_q;
  logic                              dirty_q;
  logic [1:0]                        kind_q;
  logic [ffha_pkg::ADDR_W-1:0]       addr_q;
  logic [ffha_pkg::SIZE_W-1:0]       size_q;
  logic [ffha_pkg::Q_W-1:0]          q_q;
  logic [ffha_pkg::COPY_W-1:0]       oq_q;
  logic [ffha_pkg::IDX_W-1:0]        ridx_q;
  logic [ffha_pkg::PTR_W-1:0]        i_q;
  logic [ffha_pkg::PTR_W-1:0]        k_q;
  logic signed [ffha_pkg::D_W-1:0]   d_q;
  logic [1:0]                        st_q;
  logic [ffha_pkg::ADDR_W-1:0]       res_q;
  logic [ffha_pkg::COPY_W-1:0]       copy_q;
  logic [ffha_pkg::ADDR_W-1:0]       bout_q;
  logic [1:0]                        sout_q;
  logic [ffha_pkg::COPY_W-1:0]       cout_q;

  logic [ffha_pkg::ENT_W-1:0]        ram_rdata;
  logic signed [ffha_pkg::ENT_W-1:0] rdv;
  logic [ffha_pkg::ADDR_W-1:0]       off;
  logic [ffha_pkg::ADDR_W:0]         heap_end;
  logic [ffha_pkg::IDX_W-1:0]        fidx;
  logic [ffha_pkg::SIZE_W:0]         size_rnd;
  logic [ffha_pkg::Q_W-1:0]          qcalc;
  logic signed [QXW-1:0]             d_x, q_x, oq_x, g_x;
  logic signed [ffha_pkg::D_W-1:0]   absd;
  logic [AW-1:0]                     nxt, ptr, raddr_full, waddr_full;
  logic [ffha_pkg::ENT_W-1:0]        wdata;
  logic                              ram_we;
  logic [ffha_pkg::ADDR_W-1:0]       res_alloc;

  assign rdv      = oob_q ? '0 : $signed(ram_rdata);
  assign off      = addr_q - base_q;
  assign heap_end = {1'b0, base_q} + (ffha_pkg::ADDR_W + 1)'(ffha_pkg::HEAP_SIZE_BYTES);
  assign fidx     = off[ffha_pkg::QSHIFT +: ffha_pkg::IDX_W];
  assign size_rnd = {1'b0, size_q} + (ffha_pkg::SIZE_W + 1)'(ffha_pkg::QUANTUM_BYTES - 1);
  assign qcalc    = (size_q == '0) ? ffha_pkg::Q_W'(1) :
                    size_rnd[ffha_pkg::SIZE_W:ffha_pkg::QSHIFT];

  assign d_x  = QXW'(d_q);
  assign q_x  = $signed({2'b00, q_q});
  assign oq_x = $signed(QXW'(oq_q));
  assign g_x  = d_x + oq_x;
  assign absd = (d_q < 0) ? -d_q : d_q;

  assign nxt = AW'(k_q) + AW'($unsigned(d_q)) + AW'($unsigned(rdv));
  assign ptr = AW'(k_q) + AW'($unsigned(d_q));

  always_comb begin
    case (cmd_i.rsel)
      ffha_pkg::R_FIND: raddr_full = AW'(fidx);
      ffha_pkg::R_I:    raddr_full = AW'(i_q);
      ffha_pkg::R_J:    raddr_full = AW'(ridx_q) + AW'(oq_q);
      ffha_pkg::R_NEXT: raddr_full = nxt;
      default:          raddr_full = AW'(i_q);
    endcase
  end

  always_comb begin
    waddr_full = AW'(k_q);
    wdata      = '0;
    case (cmd_i.wsel)
      ffha_pkg::W_CLR: begin
        waddr_full = AW'(cnt_q);
        wdata      = (cnt_q == '0) ? ffha_pkg::ENT_W'(N) : '0;
      end
      ffha_pkg::W_SPLIT: begin
        waddr_full = AW'(i_q) + AW'(q_q);
        wdata      = ffha_pkg::ENT_W'(d_x - q_x);
      end
      ffha_pkg::W_USE: begin
        waddr_full = AW'(i_q);
        wdata      = ffha_pkg::ENT_W'(-q_x);
      end
      ffha_pkg::W_FREE: begin
        waddr_full = AW'(ridx_q);
        wdata      = ffha_pkg::ENT_W'(oq_q);
      end
      ffha_pkg::W_ZERO: begin
        waddr_full = ptr;
      end
      ffha_pkg::W_MHEAD: begin
        wdata = ffha_pkg::ENT_W'(d_q);
      end
      ffha_pkg::W_KZERO: begin
        waddr_full = AW'(k_q);
      end
      default: begin
        waddr_full = AW'(k_q);
      end
    endcase
  end

  assign ram_we    = cmd_i.we && (waddr_full < AW'(N));
  assign res_alloc = base_q + ffha_pkg::ADDR_W'({i_q[ffha_pkg::IDX_W-1:0],
                                                 ffha_pkg::QSHIFT'(0)});

  ffha_ram #(
    .WIDTH(ffha_pkg::ENT_W),
    .DEPTH(N)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr_full[ffha_pkg::IDX_W-1:0]),
    .wdata_i(wdata),
    .raddr_i(raddr_full[ffha_pkg::IDX_W-1:0]),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      cnt_q   <= '0;
      oob_q   <= 1'b0;
      dirty_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        base_q <= cfg_data_i;
      end
      if (cmd_i.clr_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.re) begin
        oob_q <= raddr_full >= AW'(N);
      end
      if (cmd_i.d_clr) begin
        dirty_q <= 1'b0;
      end else if (cmd_i.we && cmd_i.wsel == ffha_pkg::W_ZERO) begin
        dirty_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      kind_q <= kind_i;
      addr_q <= address_i;
      size_q <= size_bytes_i;
    end
    if (cmd_i.ld_q) begin
      q_q <= qcalc;
    end
    if (cmd_i.ld_oq) begin
      oq_q <= ffha_pkg::COPY_W'(-rdv);
    end
    if (cmd_i.ld_find) begin
      ridx_q <= fidx;
    end
    if (cmd_i.i_zero) begin
      i_q <= '0;
    end else if (cmd_i.i_adv) begin
      i_q <= ffha_pkg::PTR_W'(i_q + ffha_pkg::PTR_W'($unsigned(absd)));
    end else if (cmd_i.i_ridx) begin
      i_q <= ffha_pkg::PTR_W'(ridx_q);
    end
    if (cmd_i.k_i) begin
      k_q <= i_q;
    end else if (cmd_i.k_j) begin
      k_q <= ffha_pkg::PTR_W'(ffha_pkg::PTR_W'(ridx_q) + ffha_pkg::PTR_W'(oq_q));
    end
    if (cmd_i.d_clr) begin
      d_q <= '0;
    end else if (cmd_i.d_rd) begin
      d_q <= ffha_pkg::D_W'(rdv);
    end else if (cmd_i.d_acc) begin
      d_q <= d_q + ffha_pkg::D_W'(rdv);
    end else if (cmd_i.d_oq) begin
      d_q <= ffha_pkg::D_W'(oq_x);
    end else if (cmd_i.d_grow) begin
      d_q <= ffha_pkg::D_W'(g_x);
    end
    if (cmd_i.fin) begin
      st_q   <= cmd_i.st;
      copy_q <= cmd_i.cp ? oq_q : '0;
      case (cmd_i.res)
        ffha_pkg::RES_ALLOC: res_q <= res_alloc;
        ffha_pkg::RES_ADDR:  res_q <= addr_q;
        default:             res_q <= '0;
      endcase
    end
    if (cmd_i.ld_out) begin
      bout_q <= res_q;
      sout_q <= st_q;
      cout_q <= copy_q;
    end
  end

  assign sts_o.kind      = ffha_pkg::kind_e'(kind_q);
  assign sts_o.too_big   = {1'b0, size_q} >
                           (ffha_pkg::SIZE_W + 1)'(ffha_pkg::HEAP_SIZE_BYTES);
  assign sts_o.addr_null = addr_q == '0;
  assign sts_o.find_bad  = (addr_q < base_q) || ({1'b0, addr_q} >= heap_end) ||
                           (off[ffha_pkg::QSHIFT-1:0] != '0);
  assign sts_o.clr_last  = &cnt_q;
  assign sts_o.rdv_pos   = rdv > 0;
  assign sts_o.rdv_neg   = rdv < 0;
  assign sts_o.d_pos     = d_q > 0;
  assign sts_o.d_neg     = d_q < 0;
  assign sts_o.d_ge_q    = d_x >= q_x;
  assign sts_o.d_eq_q    = d_x == q_x;
  assign sts_o.i_fits    = ((ffha_pkg::Q_W + 1)'(i_q) + {1'b0, q_q}) <=
                           (ffha_pkg::Q_W + 1)'(N);
  assign sts_o.oq_eq_q   = oq_x == q_x;
  assign sts_o.oq_gt_q   = oq_x > q_x;
  assign sts_o.grow_ok   = (d_q > 0) && (g_x >= q_x);
  assign sts_o.grow_eq   = g_x == q_x;
  assign sts_o.dirty     = dirty_q;

  assign block_address_o = bout_q;
  assign status_o        = sout_q;
  assign copy_quanta_o   = cout_q;

endmodule

>>> sim/first_fit_heap_allocator_test.sv
// Self-checking testbench of the first-fit heap allocator, with a chunk table predictor.
`timescale 1ns / 100ps

module first_fit_heap_allocator_test;

  localparam longint NQ    = ffha_pkg::HEAP_QUANTA_COUNT;
  localparam longint QB    = ffha_pkg::QUANTUM_BYTES;
  localparam longint HB    = NQ * QB;
  localparam longint MASK  = 64'hFFFF_FFFF_FFFF;

  typedef struct {
    logic [ffha_pkg::ADDR_W-1:0] block_address;
    ffha_pkg::status_e           status;
    logic [ffha_pkg::COPY_W-1:0] copy_quanta;
  } alloc_result_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [ffha_pkg::ADDR_W-1:0] cfg_data_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic [1:0]                  kind_i = ffha_pkg::K_ALLOC;
  logic [ffha_pkg::ADDR_W-1:0] address_i = '0;
  logic [ffha_pkg::SIZE_W-1:0] size_bytes_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [ffha_pkg::ADDR_W-1:0] block_address_o;
  logic [1:0]                  status_o;
  logic [ffha_pkg::COPY_W-1:0] copy_quanta_o;

  int     heap_map [ffha_pkg::HEAP_QUANTA_COUNT];
  longint heap_base;
  alloc_result_t pending_results [$];
  longint live_blocks [$];
  int     failures;
  int     results_seen;
  int     requests_sent;
  bit     busy_phase;
  int     stall_left;

  first_fit_heap_allocator dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint map_get(longint k);
    return (k >= 0 && k < NQ) ? longint'(heap_map[k]) : 0;
  endfunction

  function automatic void map_put(longint k, longint v);
    if (k >= 0 && k < NQ) heap_map[k] = int'(v);
  endfunction

  function automatic longint merge_run(longint k);
    longint d;
    longint nd;
    d = map_get(k);
    while (d > 0 && map_get(k + d) > 0) begin
      nd = d + map_get(k + d);
      map_put(k + d, 0);
      d = nd;
      map_put(k, d);
    end
    return d;
  endfunction

  function automatic longint quanta_of(longint s);
    if (s == 0) s = 1;
    return (s + QB - 1) / QB;
  endfunction

  function automatic ffha_pkg::status_e first_fit(longint size, output longint addr);
    longint q;
    longint i;
    longint d;
    addr = 0;
    if (size > HB) return ffha_pkg::ST_OOM;
    q = quanta_of(size);
    i = 0;
    while (i + q <= NQ) begin
      d = merge_run(i);
      if (d >= q) begin
        if (d != q) map_put(i + q, d - q);
        map_put(i, -q);
        addr = (heap_base + i * QB) & MASK;
        return ffha_pkg::ST_OK;
      end
      if (d > 0) i += d;
      else if (d < 0) i -= d;
      else return ffha_pkg::ST_CORRUPT;
    end
    return ffha_pkg::ST_OOM;
  endfunction

  function automatic ffha_pkg::status_e locate_block(longint addr, output longint idx,
                                                     output longint oq);
    longint off;
    longint d;
    idx = 0;
    oq = 0;
    if (addr < heap_base || addr >= heap_base + HB) return ffha_pkg::ST_BAD;
    off = addr - heap_base;
    if (off % QB != 0) return ffha_pkg::ST_BAD;
    idx = off / QB;
    d = map_get(idx);
    if (d >= 0) return ffha_pkg::ST_BAD;
    oq = -d;
    return ffha_pkg::ST_OK;
  endfunction

  function automatic alloc_result_t predict_heap(logic [1:0] kind, longint addr,
                                                longint size);
    alloc_result_t r;
    longint res;
    longint copy;
    longint i;
    longint oq;
    longint q;
    longint j;
    longint d;
    ffha_pkg::status_e st;
    res = 0;
    copy = 0;
    st = ffha_pkg::ST_OK;
    case (kind)
      ffha_pkg::K_ALLOC: st = first_fit(size, res);
      ffha_pkg::K_FREE: begin
        if (addr != 0) begin
          st = locate_block(addr, i, oq);
          if (st == ffha_pkg::ST_OK) map_put(i, oq);
        end
      end
      ffha_pkg::K_REALLOC: begin
        if (addr == 0) begin
          st = first_fit(size, res);
        end else begin
          st = locate_block(addr, i, oq);
          if (st == ffha_pkg::ST_OK) begin
            q = quanta_of(size);
            if (oq == q) begin
              res = addr;
            end else if (oq > q) begin
              map_put(i + q, oq - q);
              map_put(i, -q);
              res = addr;
            end else begin
              j = i + oq;
              d = merge_run(j);
              if (d > 0 && d >= q - oq) begin
                if (d != q - oq) map_put(i + q, d - (q - oq));
                map_put(i, -q);
                map_put(j, 0);
                res = addr;
              end else begin
                st = first_fit(size, res);
                if (st == ffha_pkg::ST_OK) begin
                  copy = oq;
                  map_put(i, oq);
                end
              end
            end
          end
        end
      end
      default: st = ffha_pkg::ST_BAD;
    endcase
    if (st != ffha_pkg::ST_OK) begin
      res = 0;
      copy = 0;
    end
    r.block_address = res[ffha_pkg::ADDR_W-1:0];
    r.status = st;
    r.copy_quanta = copy[ffha_pkg::COPY_W-1:0];
    return r;
  endfunction

  function automatic int pick_gap();
    if (!busy_phase) return 0;
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    return $urandom_range(1, 4);
  endfunction

  // Result side: random back-pressure, and the check of each accepted result.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (busy_phase && $urandom_range(0, 99) < 3) begin
      stall_left <= $urandom_range(10, 60);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !busy_phase || ($urandom_range(0, 9) < 7);
    end
  end

  always @(posedge clk_i) begin
    alloc_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result addr=%h status=%0d copy=%0d", $time,
                 block_address_o, status_o, copy_quanta_o);
        failures++;
      end else begin
        exp_r = pending_results.pop_front();
        if (block_address_o !== exp_r.block_address) begin
          $display("%0t: block_address expected %h actual %h", $time,
                   exp_r.block_address, block_address_o);
          failures++;
        end
        if (status_o !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status_o);
          failures++;
        end
        if (copy_quanta_o !== exp_r.copy_quanta) begin
          $display("%0t: copy_quanta expected %0d actual %0d", $time,
                   exp_r.copy_quanta, copy_quanta_o);
          failures++;
        end
      end
    end
  end

  task automatic send_request(input logic [1:0] kind, input longint addr,
                              input longint size, output alloc_result_t pred);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    kind_i = kind;
    address_i = addr[ffha_pkg::ADDR_W-1:0];
    size_bytes_i = size[ffha_pkg::SIZE_W-1:0];
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    pred = predict_heap(kind, addr & MASK, size & 64'hFFFF_FFFF);
    pending_results.push_back(pred);
    requests_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_base(input longint value);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = value[ffha_pkg::ADDR_W-1:0];
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    heap_base = value & MASK;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic longint live_address(int p);
    return (heap_base + live_blocks[p] * QB) & MASK;
  endfunction

  function automatic void note_block(alloc_result_t r);
    if (r.status == ffha_pkg::ST_OK)
      live_blocks.push_back(((longint'(r.block_address) - heap_base) & MASK) / QB);
  endfunction

  task automatic test_alloc_free();
    alloc_result_t r;
    longint a64;
    send_request(ffha_pkg::K_ALLOC, 0, 0, r);
    send_request(ffha_pkg::K_ALLOC, 0, 64, r);
    a64 = r.block_address;
    send_request(ffha_pkg::K_ALLOC, 0, 65, r);
    send_request(ffha_pkg::K_FREE, 0, 0, r);
    send_request(ffha_pkg::K_FREE, a64, 0, r);
    send_request(ffha_pkg::K_FREE, a64, 0, r);
    send_request(ffha_pkg::K_ALLOC, 0, 64'hFFFF_FFFF, r);
    send_request(ffha_pkg::K_ALLOC, 0, HB, r);
    send_request(ffha_pkg::K_ALLOC, 0, 1000, r);
  endtask

  task automatic test_realloc();
    alloc_result_t r;
    longint a;
    longint b;
    send_request(ffha_pkg::K_REALLOC, 0, 10, r);
    a = r.block_address;
    send_request(ffha_pkg::K_REALLOC, a, 64, r);
    send_request(ffha_pkg::K_REALLOC, a, 700, r);
    send_request(ffha_pkg::K_REALLOC, a, 200, r);
    send_request(ffha_pkg::K_ALLOC, 0, 128, r);
    b = r.block_address;
    send_request(ffha_pkg::K_REALLOC, a, 2000, r);
    send_request(ffha_pkg::K_REALLOC, b, HB + 1, r);
    send_request(ffha_pkg::K_REALLOC, b, 64'hFFFF_FFFF, r);
  endtask

  task automatic test_bad_requests();
    alloc_result_t r;
    send_request(ffha_pkg::K_FREE, 65, 0, r);
    send_request(ffha_pkg::K_FREE, MASK, 0, r);
    send_request(ffha_pkg::K_REALLOC, 128 + 64, 5, r);
    send_request(ffha_pkg::K_UNKNOWN, 0, 0, r);
    send_request(ffha_pkg::K_UNKNOWN, MASK, 64'hFFFF_FFFF, r);
  endtask

  task automatic test_base_extremes();
    alloc_result_t r;
    longint a;
    write_base(MASK - 63);
    send_request(ffha_pkg::K_ALLOC, 0, 3000, r);
    a = r.block_address;
    send_request(ffha_pkg::K_FREE, a, 0, r);
    send_request(ffha_pkg::K_FREE, MASK - 63, 0, r);
    write_base(MASK);
    send_request(ffha_pkg::K_ALLOC, 0, 1, r);
    write_base(0);
  endtask

  task automatic test_random(input int count);
    alloc_result_t r;
    int n;
    int sel;
    int p;
    longint sz;
    longint junk;
    for (n = 0; n < count; n++) begin
      if (n % 125 == 124) begin
        case ($urandom_range(0, 3))
          0: write_base(0);
          1: write_base(MASK - HB + 1);
          default: write_base({$urandom, $urandom} & MASK);
        endcase
      end
      if (n == count / 2) drain_results();
      busy_phase = (n % 100) >= 15;
      sel = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 90) sz = $urandom_range(0, 1500);
      else if ($urandom_range(0, 1) == 0) sz = $urandom_range(0, 600000);
      else sz = longint'($urandom);
      if (live_blocks.size() > 50 && sel < 40) sel = 50;
      if (live_blocks.size() == 0 && sel >= 40 && sel < 90) sel = 0;
      if (sel < 40) begin
        send_request(ffha_pkg::K_ALLOC, 0, sz, r);
        note_block(r);
      end else if (sel < 70) begin
        p = $urandom_range(0, live_blocks.size() - 1);
        send_request(ffha_pkg::K_FREE, live_address(p), 0, r);
        live_blocks.delete(p);
      end else if (sel < 90) begin
        p = $urandom_range(0, live_blocks.size() - 1);
        send_request(ffha_pkg::K_REALLOC, live_address(p), sz, r);
        if (r.status == ffha_pkg::ST_OK) begin
          live_blocks.delete(p);
          note_block(r);
        end
      end else begin
        junk = {$urandom, $urandom} & MASK;
        if ($urandom_range(0, 1) == 0) junk = (heap_base + $urandom_range(0, 9000) * 64) & MASK;
        send_request(2'($urandom_range(0, 3)), junk, longint'($urandom), r);
        if (r.status == ffha_pkg::ST_OK && r.block_address != 0) note_block(r);
      end
    end
  endtask

  initial begin
    heap_base = 0;
    failures = 0;
    results_seen = 0;
    requests_sent = 0;
    stall_left = 0;
    busy_phase = 1'b1;
    foreach (heap_map[k]) heap_map[k] = 0;
    heap_map[0] = ffha_pkg::HEAP_QUANTA_COUNT;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_alloc_free();
    test_realloc();
    test_bad_requests();
    test_base_extremes();
    test_random(500);
    drain_results();
    $display("Ran %0d requests, %0d results checked: allocate, free, reallocate,",
             requests_sent, results_seen);
    $display("bad and unknown requests, under several base addresses and random stalls.");
    if (failures == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/ffha_pkg.sv
rtl/ffha_ram.sv
rtl/ffha_ctrl.sv
rtl/ffha_dp.sv
rtl/first_fit_heap_allocator.sv
sim/first_fit_heap_allocator_test.sv
